// ===== hdl/bsc_pkg.sv =====
// ============================================================================
// Barometric sensor compensation package
// Shared widths, register indexes, record types and narrow multiply helpers.
// ============================================================================
`default_nettype none

package bsc_pkg;

    localparam int RawW    = 20;
    localparam int CalW    = 16;
    localparam int TempW   = 24;
    localparam int FineW   = 32;
    localparam int PressW  = 32;
    localparam int CfgIdxW = 8;
    localparam int WordW   = 64;
    localparam int DenW    = 32;
    localparam int QDepth  = 4;
    localparam int QPtrW   = $clog2(QDepth);
    localparam int QCntW   = $clog2(QDepth + 1);

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] RegTempCal   = 8'd0;
    localparam logic [CfgIdxW-1:0] RegPressCal1 = 8'd1;
    localparam logic [CfgIdxW-1:0] RegPressCal2 = 8'd2;
    localparam logic [CfgIdxW-1:0] RegPressCal9 = 8'd3;

    // Calibration words, all as raw 16-bit patterns.
    typedef struct packed {
        logic [CalW-1:0] t1;
        logic [CalW-1:0] t2;
        logic [CalW-1:0] t3;
        logic [CalW-1:0] p1;
        logic [CalW-1:0] p2;
        logic [CalW-1:0] p3;
        logic [CalW-1:0] p4;
        logic [CalW-1:0] p5;
        logic [CalW-1:0] p6;
        logic [CalW-1:0] p7;
        logic [CalW-1:0] p8;
        logic [CalW-1:0] p9;
    } t_cal;

    // Values that ride alongside the division.
    typedef struct packed {
        logic [TempW-1:0] temp;
        logic [TempW-1:0] tf;
        logic             invalid;
        logic             qneg;
    } t_side;

    // One division job handed from the front end to the back end.
    typedef struct packed {
        logic [WordW-1:0] num;
        logic [DenW-1:0]  den;
        t_side            side;
    } t_job;

    // Low 64 bits of a 64-bit word times an unsigned 16-bit word.
    function automatic logic [WordW-1:0] mul_u16(input logic [WordW-1:0] x,
                                                 input logic [CalW-1:0] u);
        logic [47:0] lo;
        logic [31:0] hi;
        lo = x[31:0] * u;
        hi = x[63:32] * u;
        mul_u16 = WordW'(lo) + {hi, 32'd0};
    endfunction

    // Low 64 bits of a 64-bit word times a signed 16-bit word.
    function automatic logic [WordW-1:0] mul_s16(input logic [WordW-1:0] x,
                                                 input logic [CalW-1:0] s);
        logic [WordW-1:0] corr;
        corr = s[CalW-1] ? (x << CalW) : '0;
        mul_s16 = mul_u16(x, s) - corr;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bsc_front.sv =====
// ============================================================================
// Compensation front end
// Temperature path and the pressure divisor and dividend, eleven stages.
// ============================================================================
`default_nettype none

module bsc_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [bsc_pkg::RawW-1:0] i_adc_p,
    input  wire logic [bsc_pkg::RawW-1:0] i_adc_t,
    input  wire bsc_pkg::t_cal         i_cal,
    input  wire logic                  i_full,
    output logic                       o_push,
    output bsc_pkg::t_job              o_job
);
    import bsc_pkg::*;

    localparam int NStg = 11;

    logic [NStg:1] r_v;
    logic          w_en;

    logic [RawW-1:0]  r1_adc_p, r1_adc_t;
    logic signed [33:0] r2_pa, r2_dd;
    logic [RawW-1:0]  r2_adc_p;
    logic signed [22:0] r3_ta;
    logic signed [37:0] r3_tb;
    logic [RawW-1:0]  r3_adc_p;
    logic signed [TempW-1:0] r4_tf;
    logic [RawW-1:0]  r4_adc_p;
    logic signed [TempW-1:0] r5_temp, r5_tf;
    logic signed [24:0] r5_a;
    logic [RawW-1:0]  r5_adc_p;
    logic signed [49:0] r6_aa;
    logic signed [40:0] r6_ap5, r6_ap2;
    logic [TempW-1:0] r6_temp, r6_tf;
    logic [RawW-1:0]  r6_adc_p;
    logic [WordW-1:0] r7_bp6, r7_ap3;
    logic signed [40:0] r7_ap5, r7_ap2;
    logic [TempW-1:0] r7_temp, r7_tf;
    logic [RawW-1:0]  r7_adc_p;
    logic [WordW-1:0] r8_b, r8_c1;
    logic [TempW-1:0] r8_temp, r8_tf;
    logic [RawW-1:0]  r8_adc_p;
    logic [WordW-1:0] r9_pr, r9_np;
    logic [TempW-1:0] r9_temp, r9_tf;
    logic signed [30:0] r10_den;
    logic [WordW-1:0] r10_num;
    logic [TempW-1:0] r10_temp, r10_tf;
    t_job             r11_job;

    logic signed [17:0] w_x1;
    logic signed [16:0] w_d;
    logic signed [26:0] w_tf27, w_t5;
    logic signed [WordW-1:0] w_ap3_sh;
    logic [20:0]      w_pd;
    logic signed [DenW-1:0] w_den_ext;
    logic             w_dneg, w_nneg;

    assign w_en    = !(r_v[NStg] && i_full);
    assign o_ready = w_en;
    assign o_push  = r_v[NStg] && !i_full;
    assign o_job   = r11_job;

    always_comb begin
        w_x1      = $signed({1'b0, r1_adc_t[19:3]}) - $signed({1'b0, i_cal.t1, 1'b0});
        w_d       = $signed({1'b0, r1_adc_t[19:4]}) - $signed({1'b0, i_cal.t1});
        w_tf27    = 27'(r4_tf);
        w_t5      = (w_tf27 <<< 2) + w_tf27 + 27'sd128;
        w_ap3_sh  = $signed(r7_ap3) >>> 8;
        w_pd      = 21'd1048576 - {1'b0, r8_adc_p};
        w_den_ext = 32'(r10_den);
        w_dneg    = r10_den[30];
        w_nneg    = r10_num[WordW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NStg-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_adc_p <= i_adc_p;
            r1_adc_t <= i_adc_t;

            r2_pa    <= w_x1 * $signed(i_cal.t2);
            r2_dd    <= w_d * w_d;
            r2_adc_p <= r1_adc_p;

            r3_ta    <= r2_pa[33:11];
            r3_tb    <= $signed(r2_dd[33:12]) * $signed(i_cal.t3);
            r3_adc_p <= r2_adc_p;

            r4_tf    <= 24'(r3_ta) + $signed(r3_tb[37:14]);
            r4_adc_p <= r3_adc_p;

            r5_temp  <= 24'($signed(w_t5[26:8]));
            r5_tf    <= r4_tf;
            r5_a     <= 25'(r4_tf) - 25'sd128000;
            r5_adc_p <= r4_adc_p;

            r6_aa    <= r5_a * r5_a;
            r6_ap5   <= r5_a * $signed(i_cal.p5);
            r6_ap2   <= r5_a * $signed(i_cal.p2);
            r6_temp  <= r5_temp;
            r6_tf    <= r5_tf;
            r6_adc_p <= r5_adc_p;

            r7_bp6   <= mul_s16(64'(r6_aa), i_cal.p6);
            r7_ap3   <= mul_s16(64'(r6_aa), i_cal.p3);
            r7_ap5   <= r6_ap5;
            r7_ap2   <= r6_ap2;
            r7_temp  <= r6_temp;
            r7_tf    <= r6_tf;
            r7_adc_p <= r6_adc_p;

            r8_b     <= r7_bp6 + (64'(r7_ap5) << 17) + (64'($signed(i_cal.p4)) << 35);
            r8_c1    <= 64'h0000_8000_0000_0000 + w_ap3_sh + (64'(r7_ap2) << 12);
            r8_temp  <= r7_temp;
            r8_tf    <= r7_tf;
            r8_adc_p <= r7_adc_p;

            r9_pr    <= mul_u16(r8_c1, i_cal.p1);
            r9_np    <= ({43'd0, w_pd} << 31) - r8_b;
            r9_temp  <= r8_temp;
            r9_tf    <= r8_tf;

            r10_den  <= $signed(r9_pr[63:33]);
            r10_num  <= mul_u16(r9_np, 16'd3125);
            r10_temp <= r9_temp;
            r10_tf   <= r9_tf;

            r11_job.num          <= w_nneg ? (~r10_num + 64'd1) : r10_num;
            r11_job.den          <= w_dneg ? (~w_den_ext + 32'd1) : w_den_ext;
            r11_job.side.temp    <= r10_temp;
            r11_job.side.tf      <= r10_tf;
            r11_job.side.invalid <= (r10_den == '0);
            r11_job.side.qneg    <= w_nneg ^ w_dneg;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bsc_queue.sv =====
// ============================================================================
// Job queue
// Short first-in first-out buffer between the front end and the back end.
// ============================================================================
`default_nettype none

module bsc_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire bsc_pkg::t_job i_item,
    output logic               o_full,
    input  wire logic          i_pop,
    output bsc_pkg::t_job      o_item,
    output logic               o_empty
);
    import bsc_pkg::*;

    t_job             r_mem [0:QDepth-1];
    logic [QPtrW-1:0] r_wr, r_rd;
    logic [QCntW-1:0] r_cnt;

    assign o_full  = (r_cnt == QCntW'(QDepth));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue read while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCntW'(QDepth)) else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== hdl/bsc_div.sv =====
// ============================================================================
// Pipelined divider
// Unsigned 64-bit by 32-bit restoring division, one quotient bit per stage.
// ============================================================================
`default_nettype none

module bsc_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire logic [bsc_pkg::WordW-1:0] i_num,
    input  wire logic [bsc_pkg::DenW-1:0]  i_den,
    input  wire bsc_pkg::t_side           i_side,
    output logic                          o_valid,
    output logic [bsc_pkg::WordW-1:0]     o_quot,
    output bsc_pkg::t_side                o_side
);
    import bsc_pkg::*;

    logic [WordW-1:0] r_v;
    logic [DenW-1:0]  r_rem  [0:WordW-1];
    logic [WordW-1:0] r_num  [0:WordW-1];
    logic [DenW-1:0]  r_den  [0:WordW-1];
    t_side            r_side [0:WordW-1];

    logic [DenW-1:0]  a_rem  [0:WordW-1];
    logic [WordW-1:0] a_num  [0:WordW-1];
    logic [DenW-1:0]  a_den  [0:WordW-1];
    t_side            a_side [0:WordW-1];
    logic [DenW-1:0]  n_rem  [0:WordW-1];
    logic [WordW-1:0] n_num  [0:WordW-1];

    always_comb begin
        logic [DenW-1:0] trial;
        logic            ge;
        a_rem[0]  = '0;
        a_num[0]  = i_num;
        a_den[0]  = i_den;
        a_side[0] = i_side;
        for (int k = 1; k < WordW; k++) begin
            a_rem[k]  = r_rem[k-1];
            a_num[k]  = r_num[k-1];
            a_den[k]  = r_den[k-1];
            a_side[k] = r_side[k-1];
        end
        for (int k = 0; k < WordW; k++) begin
            trial    = {a_rem[k][DenW-2:0], a_num[k][WordW-1]};
            ge       = (trial >= a_den[k]);
            n_rem[k] = ge ? (trial - a_den[k]) : trial;
            n_num[k] = {a_num[k][WordW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[WordW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < WordW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_num[k]  <= n_num[k];
                r_den[k]  <= a_den[k];
                r_side[k] <= a_side[k];
            end
        end
    end

    assign o_valid = r_v[WordW-1];
    assign o_quot  = r_num[WordW-1];
    assign o_side  = r_side[WordW-1];

endmodule

`default_nettype wire

// ===== hdl/bsc_back.sv =====
// ============================================================================
// Compensation back end
// Division, second-order pressure correction, saturation and output register.
// ============================================================================
`default_nettype none

module bsc_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire bsc_pkg::t_cal             i_cal,
    input  wire logic                      i_empty,
    input  wire bsc_pkg::t_job             i_job,
    output logic                           o_pop,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [bsc_pkg::TempW-1:0]      o_temp,
    output logic [bsc_pkg::PressW-1:0]     o_press,
    output logic [bsc_pkg::FineW-1:0]      o_fine,
    output logic                           o_invalid
);
    import bsc_pkg::*;

    logic             w_en;
    logic             w_dv;
    logic [WordW-1:0] w_dq;
    t_side            w_ds;

    logic [5:1]       r_pv;
    logic [WordW-1:0] r1_p, r2_p, r3_p, r4_p;
    logic [WordW-1:0] r2_ll, r2_e0, r3_q2, r3_e, r4_c0, r4_e, r5_sum;
    logic [31:0]      r2_lh;
    t_side            r1_s, r2_s, r3_s, r4_s, r5_s;

    logic                    r_out_valid;
    logic [TempW-1:0]        r_out_temp;
    logic [PressW-1:0]       r_out_press;
    logic [FineW-1:0]        r_out_fine;
    logic                    r_out_inv;

    logic signed [WordW-1:0] w_q, w_e, w_c, w_r;
    logic [WordW-1:0]        w_res;
    logic [PressW-1:0]       w_press;

    assign w_en  = !(r_out_valid && !i_ready);
    assign o_pop = !i_empty && w_en;

    bsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (o_pop),
        .i_num   (i_job.num),
        .i_den   (i_job.den),
        .i_side  (i_job.side),
        .o_valid (w_dv),
        .o_quot  (w_dq),
        .o_side  (w_ds)
    );

    always_comb begin
        w_q   = $signed(r1_p) >>> 13;
        w_e   = $signed(r2_e0) >>> 19;
        w_c   = $signed(r4_c0) >>> 25;
        w_r   = $signed(r5_sum) >>> 8;
        w_res = w_r + (64'($signed(i_cal.p7)) << 4);
        if (r5_s.invalid || w_res[WordW-1]) begin
            w_press = '0;
        end else if (w_res[WordW-1:PressW] != '0) begin
            w_press = '1;
        end else begin
            w_press = w_res[PressW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv        <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_pv        <= {r_pv[4:1], w_dv};
            r_out_valid <= r_pv[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_p   <= w_ds.qneg ? (~w_dq + 64'd1) : w_dq;
            r1_s   <= w_ds;

            r2_ll  <= w_q[31:0] * w_q[31:0];
            r2_lh  <= w_q[31:0] * w_q[63:32];
            r2_e0  <= mul_s16(r1_p, i_cal.p8);
            r2_p   <= r1_p;
            r2_s   <= r1_s;

            r3_q2  <= r2_ll + (64'(r2_lh) << 33);
            r3_e   <= w_e;
            r3_p   <= r2_p;
            r3_s   <= r2_s;

            r4_c0  <= mul_s16(r3_q2, i_cal.p9);
            r4_e   <= r3_e;
            r4_p   <= r3_p;
            r4_s   <= r3_s;

            r5_sum <= r4_p + w_c + r4_e;
            r5_s   <= r4_s;

            r_out_temp  <= r5_s.temp;
            r_out_fine  <= 32'($signed(r5_s.tf));
            r_out_press <= w_press;
            r_out_inv   <= r5_s.invalid;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_temp    = r_out_temp;
    assign o_press   = r_out_press;
    assign o_fine    = r_out_fine;
    assign o_invalid = r_out_inv;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_inv |-> r_out_press == '0)
        else $error("invalid pressure result is not zero");

endmodule

`default_nettype wire

// ===== hdl/barometric_sensor_compensation.sv =====
// ============================================================================
// Barometric sensor compensation
// Integer temperature and pressure compensation of raw 20-bit sensor samples.
// ============================================================================
// The path from input acceptance to the result showing on the output:
// eleven front stages, one queue write, 64 divider stages, five back stages
// and the output register. Output stalls hold the divider and back stages; a full queue holds the front.
// Throughput, unless stalled: one item per cycle, also through the 64-stage divider.
// Reset (i_rst_n low at a clock edge) empties every stage and the queue and
// clears all four calibration registers to zero.
`default_nettype none

module barometric_sensor_compensation (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input items. tdata: raw_pressure [19:0], raw_temperature [39:20].
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,
    // Result items. tdata: temperature_centi [23:0], pressure_q24_8 [55:24],
    // fine_temperature [87:56]. tuser: pressure_invalid [0].
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata,
    output logic             m_axis_tuser,
    // Calibration register writes.
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [bsc_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [bsc_pkg::WordW-1:0]     i_cfg_data
);
    import bsc_pkg::*;

    // The calibration registers. The user must change them only while the block is idle;
    // the block itself does not enforce this, and every stage reads them directly.
    logic [47:0]      r_cal_t;
    logic [WordW-1:0] r_cal_p1;
    logic [WordW-1:0] r_cal_p2;
    logic [CalW-1:0]  r_cal_p9;
    t_cal             w_cal;

    logic  w_push, w_full, w_pop, w_empty;
    t_job  w_job_in, w_job_out;

    logic [TempW-1:0]  w_temp;
    logic [PressW-1:0] w_press;
    logic [FineW-1:0]  w_fine;

    // Writes are always taken at once.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t  <= '0;
            r_cal_p1 <= '0;
            r_cal_p2 <= '0;
            r_cal_p9 <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegTempCal:   r_cal_t  <= i_cfg_data[47:0];
                RegPressCal1: r_cal_p1 <= i_cfg_data;
                RegPressCal2: r_cal_p2 <= i_cfg_data;
                RegPressCal9: r_cal_p9 <= i_cfg_data[CalW-1:0];
                default: ;
            endcase
        end
    end

    // Split the packed registers into the twelve calibration words.
    assign w_cal.t1 = r_cal_t[15:0];
    assign w_cal.t2 = r_cal_t[31:16];
    assign w_cal.t3 = r_cal_t[47:32];
    assign w_cal.p1 = r_cal_p1[15:0];
    assign w_cal.p2 = r_cal_p1[31:16];
    assign w_cal.p3 = r_cal_p1[47:32];
    assign w_cal.p4 = r_cal_p1[63:48];
    assign w_cal.p5 = r_cal_p2[15:0];
    assign w_cal.p6 = r_cal_p2[31:16];
    assign w_cal.p7 = r_cal_p2[47:32];
    assign w_cal.p8 = r_cal_p2[63:48];
    assign w_cal.p9 = r_cal_p9;

    // The front end finishes the temperature path and reduces the pressure
    // path to one dividend and one divisor, flagging a zero divisor.
    bsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_adc_p (s_axis_tdata[19:0]),
        .i_adc_t (s_axis_tdata[39:20]),
        .i_cal   (w_cal),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_job_in)
    );

    // The queue lets the front end keep taking items while the back end
    // waits on the output.
    bsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_item  (w_job_out),
        .o_empty (w_empty)
    );

    // The back end divides, applies the second-order pressure terms,
    // saturates and holds the result in its output register.
    bsc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cal     (w_cal),
        .i_empty   (w_empty),
        .i_job     (w_job_out),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_temp    (w_temp),
        .o_press   (w_press),
        .o_fine    (w_fine),
        .o_invalid (m_axis_tuser)
    );

    assign m_axis_tdata = {w_fine, w_press, w_temp};

endmodule

`default_nettype wire

// ===== bench/barometric_sensor_compensation_chk.sv =====
// ============================================================================
// Barometric compensation checker
// Watches the calibration, input and result channels. It predicts each result
// from its own copy of the calibration words and compares field by field.
// ============================================================================
`default_nettype none

module barometric_sensor_compensation_chk (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [39:0] i_in_data,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [87:0] i_out_data,
    input  wire logic        i_out_user,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [23:0] temp_centi;
        logic [31:0] press_q24_8;
        logic [31:0] fine_temp;
        logic        invalid;
    } t_comp;

    logic [47:0] temp_cal;
    logic [63:0] press_cal_a;
    logic [63:0] press_cal_b;
    logic [15:0] press_cal_p9;
    t_comp       comp_queue[$];
    int          fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = comp_queue.size();

    function automatic logic [63:0] sext16(input logic [15:0] w);
        return {{48{w[15]}}, w};
    endfunction

    function automatic logic [63:0] sra(input logic [63:0] x, input int n);
        return 64'($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] sat(input logic [63:0] x, input logic [63:0] lo,
                                        input logic [63:0] hi);
        if ($signed(x) < $signed(lo)) return lo;
        if ($signed(x) > $signed(hi)) return hi;
        return x;
    endfunction

    // Signed quotient truncated toward zero, computed on magnitudes so that the
    // most negative value over minus one wraps to itself.
    function automatic logic [63:0] quot(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] mn, md, q;
        mn = num[63] ? -num : num;
        md = den[63] ? -den : den;
        q  = mn / md;
        return (num[63] != den[63]) ? -q : q;
    endfunction

    function automatic t_comp compensate(input logic [39:0] d);
        logic [63:0] adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] a, b, dt, tf, tc, p, q, c, e, pr;
        t_comp r;
        adc_p = 64'(d[19:0]);
        adc_t = 64'(d[39:20]);
        t1 = 64'(temp_cal[15:0]);
        t2 = sext16(temp_cal[31:16]);
        t3 = sext16(temp_cal[47:32]);
        p1 = 64'(press_cal_a[15:0]);
        p2 = sext16(press_cal_a[31:16]);
        p3 = sext16(press_cal_a[47:32]);
        p4 = sext16(press_cal_a[63:48]);
        p5 = sext16(press_cal_b[15:0]);
        p6 = sext16(press_cal_b[31:16]);
        p7 = sext16(press_cal_b[47:32]);
        p8 = sext16(press_cal_b[63:48]);
        p9 = sext16(press_cal_p9);
        // Temperature path.
        a  = sra(((adc_t >> 3) - (t1 << 1)) * t2, 11);
        dt = (adc_t >> 4) - t1;
        b  = sra(sra(dt * dt, 12) * t3, 14);
        tf = sat(a + b, 64'hFFFF_FFFF_8000_0000, 64'h7FFF_FFFF);
        tc = sat(sra(tf * 5 + 128, 8), 64'hFFFF_FFFF_FF80_0000, 64'h7F_FFFF);
        // Pressure path, all wrapping 64-bit.
        a = tf - 64'd128000;
        b = a * a * p6;
        b = b + ((a * p5) << 17);
        b = b + (p4 << 35);
        a = sra(a * a * p3, 8) + ((a * p2) << 12);
        a = sra(((64'd1 << 47) + a) * p1, 33);
        if (a == 0) begin
            r.invalid = 1'b1;
            pr = '0;
        end else begin
            r.invalid = 1'b0;
            p  = 64'd1048576 - adc_p;
            p  = quot(((p << 31) - b) * 64'd3125, a);
            q  = sra(p, 13);
            c  = sra(p9 * q * q, 25);
            e  = sra(p8 * p, 19);
            p  = sra(p + c + e, 8) + (p7 << 4);
            pr = sat(p, 64'd0, 64'hFFFF_FFFF);
        end
        r.temp_centi  = tc[23:0];
        r.press_q24_8 = pr[31:0];
        r.fine_temp   = tf[31:0];
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_comp want;
        if (!i_rst_n) begin
            temp_cal     <= '0;
            press_cal_a  <= '0;
            press_cal_b  <= '0;
            press_cal_p9 <= '0;
            comp_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    bsc_pkg::RegTempCal:   temp_cal     <= i_cfg_data[47:0];
                    bsc_pkg::RegPressCal1: press_cal_a  <= i_cfg_data;
                    bsc_pkg::RegPressCal2: press_cal_b  <= i_cfg_data;
                    bsc_pkg::RegPressCal9: press_cal_p9 <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                comp_queue.push_back(compensate(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (comp_queue.size() == 0) begin
                    report("unexpected result", i_out_data[63:0], '0);
                end else begin
                    want = comp_queue.pop_front();
                    if (i_out_data[23:0] != want.temp_centi)
                        report("temperature_centi", 64'(i_out_data[23:0]),
                               64'(want.temp_centi));
                    if (i_out_data[55:24] != want.press_q24_8)
                        report("pressure_q24_8", 64'(i_out_data[55:24]),
                               64'(want.press_q24_8));
                    if (i_out_data[87:56] != want.fine_temp)
                        report("fine_temperature", 64'(i_out_data[87:56]),
                               64'(want.fine_temp));
                    if (i_out_user != want.invalid)
                        report("pressure_invalid", 64'(i_out_user), 64'(want.invalid));
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== bench/barometric_sensor_compensation_tb.sv =====
// ============================================================================
// Barometric compensation testbench
// Drives raw sample pairs through several calibration settings with bursty
// input and a stalling receiver; the checker predicts and compares results.
// ============================================================================
`default_nettype none

module barometric_sensor_compensation_tb;

    // An index outside the register list; the block must ignore the write.
    localparam logic [7:0] UnusedReg  = 8'd200;
    localparam int         CycleLimit = 300000;
    localparam int         Latency    = 82;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          gap_bias = 0;

    always #1 i_clk = ~i_clk;

    barometric_sensor_compensation u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    barometric_sensor_compensation_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_data    (s_tdata),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .i_out_user   (m_tuser),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // The run is bounded by a plain cycle count, in case the block hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // The receiver rotates in turn through always ready, a random
    // half-rate stall, and long stalls with rare ready cycles.
    always @(posedge i_clk) begin
        int mode;
        mode = (cycles / 64) % 3;
        case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(1, 0));
            default: m_tready <= ($urandom_range(7, 0) == 0);
        endcase
    end

    // Presents one item and holds it until accepted. Burst mode decides whether
    // the valid drops for a random gap afterward; a following item with no gap
    // keeps valid high without lowering it.
    task automatic send_item(input logic [19:0] raw_p, input logic [19:0] raw_t);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {raw_t, raw_p};
        do @(posedge i_clk); while (!s_tready);
        gap = 0;
        if (gap_bias > 0) begin
            gap_bias--;
        end else begin
            gap_bias = $urandom_range(12, 0);
            gap = $urandom_range(6, 1);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Register writes happen only once every result is back and the pipeline
    // has had its full latency to drain. The first edge lets the checker
    // record an item accepted at the edge just passed.
    task automatic write_reg(input logic [7:0] idx, input logic [63:0] value);
        s_tvalid  <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_cal(input logic [47:0] tc, input logic [63:0] pa,
                            input logic [63:0] pb, input logic [15:0] p9);
        write_reg(bsc_pkg::RegTempCal, {16'hA5A5, tc});
        write_reg(bsc_pkg::RegPressCal1, pa);
        write_reg(bsc_pkg::RegPressCal2, pb);
        write_reg(bsc_pkg::RegPressCal9, {48'hFFFF_0000_1234, p9});
    endtask

    // Raw readings: mostly near the usual operating point, sometimes anywhere.
    task automatic random_items(input int count);
        repeat (count) begin
            if ($urandom_range(3, 0) == 0)
                send_item(20'($urandom_range(20'hFFFFF, 0)),
                          20'($urandom_range(20'hFFFFF, 0)));
            else
                send_item(20'($urandom_range(430000, 250000)),
                          20'($urandom_range(560000, 480000)));
        end
    endtask

    task automatic directed_items();
        send_item(20'h00000, 20'h00000);
        send_item(20'hFFFFF, 20'hFFFFF);
        send_item(20'h00000, 20'hFFFFF);
        send_item(20'hFFFFF, 20'h00000);
        send_item(20'h55555, 20'hAAAAA);
        send_item(20'hAAAAA, 20'h55555);
        send_item(20'd415148, 20'd519888);
        send_item(20'h80000, 20'h80000);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset calibration: every divisor is zero, so pressure is flagged.
        directed_items();
        random_items(40);

        // Typical factory calibration words.
        load_cal({16'hFC18, 16'd26435, 16'd27504},
                 {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                 {-16'sd14600, 16'd15500, -16'sd7, 16'd140}, 16'd6000);
        directed_items();
        random_items(150);

        // Every calibration bit set.
        load_cal('1, '1, '1, '1);
        directed_items();
        random_items(60);

        // Most negative words and the largest unsigned ones.
        load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
                 {4{16'h8000}}, 16'h8000);
        write_reg(UnusedReg, '1);
        directed_items();
        random_items(60);

        // Largest positive signed words, smallest nonzero dividing word.
        load_cal({16'h7FFF, 16'h7FFF, 16'h0000}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001},
                 {4{16'h7FFF}}, 16'h7FFF);
        random_items(40);

        // Fully random calibration settings.
        repeat (4) begin
            load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                     {$urandom, $urandom}, 16'($urandom));
            random_items(50);
        end

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (Latency + 20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
